### design/scbp_pkg.sv
// Shared types and constants of the size class block pool.
`default_nettype none

package scbp_pkg;

    // Field and register widths
    localparam int CLASS_SLOTS = 4;
    localparam int CLASS_W     = 2;
    localparam int SIZE_W      = 16;
    localparam int COUNT_W     = 11;
    localparam int SUM_W       = 13;
    localparam int HANDLE_W    = 10;
    localparam int LINK_W      = 11;
    localparam int TYPE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int REG_IDX_W   = 3;

    // Port widths
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    // Parameter defaults
    localparam int MAX_CLASSES_DEF  = 4;
    localparam int TOTAL_BLOCKS_DEF = 1024;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_CLASS0_SIZE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLASS0_COUNT = 3'd4;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INIT,
        REQ_ALLOC,
        REQ_FREE,
        REQ_REALLOC
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_BLOCK,
        ST_NO_CLASS,
        ST_BAD_CONFIG
    } status_t;

    typedef enum logic [2:0] {
        RES_INIT,
        RES_BAD,
        RES_NOBLK,
        RES_NOCLASS,
        RES_KEEP,
        RES_ALLOC
    } res_kind_t;

    // Class sizes and handle ranges, as the datapath sees them
    typedef struct packed {
        logic [CLASS_SLOTS-1:0][SIZE_W-1:0] size;
        logic [CLASS_SLOTS-1:0][SUM_W-1:0]  base;
        logic [CLASS_SLOTS-1:0][SUM_W-1:0]  stop;
        logic [SUM_W-1:0]                   total;
    } scbp_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_req;
        logic      heads_init;
        logic      heads_clear;
        logic      walk_start;
        logic      walk_step;
        logic      pop_read;
        logic      pop_commit;
        logic      push;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } scbp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_type_t req_type;
        logic      owner_hit;
        logic      owner_fits;
        logic      alloc_hit;
        logic      total_over;
        logic      total_zero;
        logic      walk_last;
        logic      out_free;
    } scbp_stat_t;

endpackage

`default_nettype wire

### design/scbp_regs.sv
// Configuration registers with derived class handle ranges.
`default_nettype none

module scbp_regs #(
    parameter int MAX_CLASSES = scbp_pkg::MAX_CLASSES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scbp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [scbp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [scbp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output scbp_pkg::scbp_cfg_t              cfg
);
    import scbp_pkg::*;

    logic [CLASS_SLOTS-1:0][SIZE_W-1:0]  size_reg;
    logic [CLASS_SLOTS-1:0][COUNT_W-1:0] count_reg;
    logic [CLASS_SLOTS-1:0][SUM_W-1:0]   base_reg;
    logic [CLASS_SLOTS-1:0][SUM_W-1:0]   base_next;
    logic [CLASS_SLOTS-1:0][SUM_W-1:0]   stop_reg;
    logic [CLASS_SLOTS-1:0][SUM_W-1:0]   stop_next;
    logic [SUM_W-1:0]                    total_reg;
    logic [SUM_W-1:0]                    total_next;
    logic [SUM_W-1:0]                    acc;
    logic                                wr_en;
    logic [REG_IDX_W-1:0]                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Read back the addressed register
    always_comb begin
        if (reg_idx < REG_CLASS0_COUNT) begin
            prdata = APB_DATA_W'(size_reg[2'(reg_idx - REG_CLASS0_SIZE)]);
        end else begin
            prdata = APB_DATA_W'(count_reg[2'(reg_idx - REG_CLASS0_COUNT)]);
        end
    end

    // Prefix sums of the active class counts give each class its range
    always_comb begin
        acc = '0;
        for (int c = 0; c < CLASS_SLOTS; c++) begin
            base_next[c] = acc;
            if (c < MAX_CLASSES) begin
                acc = acc + SUM_W'(count_reg[c]);
            end
            stop_next[c] = acc;
        end
        total_next = acc;
    end

    // Hold registers and refresh ranges every cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= '0;
            count_reg <= '0;
            base_reg  <= '0;
            stop_reg  <= '0;
            total_reg <= '0;
        end else begin
            if (wr_en) begin
                if (reg_idx < REG_CLASS0_COUNT) begin
                    size_reg[2'(reg_idx - REG_CLASS0_SIZE)] <= pwdata[SIZE_W-1:0];
                end else begin
                    count_reg[2'(reg_idx - REG_CLASS0_COUNT)] <= pwdata[COUNT_W-1:0];
                end
            end
            base_reg  <= base_next;
            stop_reg  <= stop_next;
            total_reg <= total_next;
        end
    end

    assign cfg.size  = size_reg;
    assign cfg.base  = base_reg;
    assign cfg.stop  = stop_reg;
    assign cfg.total = total_reg;

endmodule

`default_nettype wire

### design/scbp_dp.sv
// Datapath: request latch, list heads, link memory, result and output registers.
`default_nettype none

module scbp_dp #(
    parameter int MAX_CLASSES  = scbp_pkg::MAX_CLASSES_DEF,
    parameter int TOTAL_BLOCKS = scbp_pkg::TOTAL_BLOCKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  scbp_pkg::scbp_cfg_t              cfg,
    input  scbp_pkg::scbp_cmd_t              cmd,
    output scbp_pkg::scbp_stat_t             stat,
    input  logic [scbp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [scbp_pkg::TYPE_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [scbp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [scbp_pkg::STATUS_W-1:0]    m_tuser
);
    import scbp_pkg::*;

    localparam int IDX_W = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TOTAL_BLOCKS);

    // Request latch
    req_type_t             req_type_reg;
    logic [SIZE_W-1:0]     req_size_reg;
    logic [HANDLE_W-1:0]   req_handle_reg;

    // List heads and link store
    logic [MAX_CLASSES-1:0][LINK_W-1:0] head_reg;
    logic [LINK_W-1:0]     link_mem [TOTAL_BLOCKS];
    logic [LINK_W-1:0]     link_rd_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [LINK_W-1:0]     mem_wdata;

    // Lookup results
    logic                  own_hit;
    logic [CLASS_W-1:0]    own_cls;
    logic [SIZE_W-1:0]     own_size;
    logic [SUM_W-1:0]      h_ext;
    logic                  alloc_hit;
    logic [CLASS_W-1:0]    alloc_cls;
    logic [LINK_W-1:0]     alloc_head;
    logic [CLASS_W-1:0]    alloc_cls_reg;
    logic [LINK_W-1:0]     alloc_head_reg;
    logic [CLASS_W-1:0]    own_cls_reg;
    logic [CLASS_W-1:0]    push_cls;
    logic [LINK_W-1:0]     push_head;

    // Init walk
    logic [IDX_W-1:0]      walk_ptr_reg;
    logic [SUM_W-1:0]      walk_succ;
    logic                  walk_end;
    logic [LINK_W-1:0]     walk_link;

    // Result and output registers
    logic [HANDLE_W-1:0]   res_handle_reg;
    logic [CLASS_W-1:0]    res_class_reg;
    status_t               res_status_reg;
    logic                  m_valid_reg;
    logic [HANDLE_W-1:0]   m_handle_reg;
    logic [CLASS_W-1:0]    m_class_reg;
    status_t               m_status_reg;

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg   <= req_type_t'(s_tuser);
            req_size_reg   <= s_tdata[SIZE_W-1:0];
            req_handle_reg <= s_tdata[SIZE_W+HANDLE_W-1:SIZE_W];
        end
    end

    // Find the class that owns the request handle
    always_comb begin
        own_hit  = 1'b0;
        own_cls  = '0;
        own_size = '0;
        h_ext    = SUM_W'(req_handle_reg);
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (!own_hit && h_ext >= cfg.base[c] && h_ext < cfg.stop[c]) begin
                own_hit  = 1'b1;
                own_cls  = CLASS_W'(c);
                own_size = cfg.size[c];
            end
        end
        if (LINK_W'(req_handle_reg) >= NULL_LINK) begin
            own_hit = 1'b0;
        end
    end

    // Pick the first fitting class with a free block
    always_comb begin
        alloc_hit  = 1'b0;
        alloc_cls  = '0;
        alloc_head = NULL_LINK;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (!alloc_hit && req_size_reg <= cfg.size[c] && head_reg[c] < NULL_LINK) begin
                alloc_hit  = 1'b1;
                alloc_cls  = CLASS_W'(c);
                alloc_head = head_reg[c];
            end
        end
    end

    // Head of the class that takes a pushed block
    always_comb begin
        push_cls  = cmd.pop_commit ? own_cls_reg : own_cls;
        push_head = NULL_LINK;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (push_cls == CLASS_W'(c)) begin
                push_head = head_reg[c];
            end
        end
    end

    // Successor link of the block under the walk pointer
    always_comb begin
        walk_succ = SUM_W'(walk_ptr_reg) + SUM_W'(1);
        walk_end  = 1'b0;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (cfg.stop[c] != cfg.base[c] && cfg.stop[c] == walk_succ) begin
                walk_end = 1'b1;
            end
        end
        walk_link = walk_end ? NULL_LINK : LINK_W'(walk_succ);
    end

    // Link store write port: init walk or push
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = walk_ptr_reg;
        mem_wdata = walk_link;
        if (cmd.walk_step) begin
            mem_we = 1'b1;
        end else if (cmd.push) begin
            mem_we    = 1'b1;
            mem_waddr = req_handle_reg[IDX_W-1:0];
            mem_wdata = push_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.pop_read) begin
            link_rd_reg <= link_mem[alloc_head[IDX_W-1:0]];
        end
    end

    // Hold the chosen classes across the pop
    always_ff @(posedge aclk) begin
        if (cmd.pop_read) begin
            alloc_cls_reg  <= alloc_cls;
            alloc_head_reg <= alloc_head;
            own_cls_reg    <= own_cls;
        end
    end

    // Advance the walk pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_ptr_reg <= '0;
        end else if (cmd.walk_start) begin
            walk_ptr_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_ptr_reg <= walk_ptr_reg + IDX_W'(1);
        end
    end

    // Update the list heads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAX_CLASSES; c++) begin
                head_reg[c] <= NULL_LINK;
            end
        end else begin
            for (int c = 0; c < MAX_CLASSES; c++) begin
                if (cmd.heads_clear) begin
                    head_reg[c] <= NULL_LINK;
                end else if (cmd.heads_init) begin
                    head_reg[c] <= (cfg.stop[c] != cfg.base[c]) ?
                                   LINK_W'(cfg.base[c]) : NULL_LINK;
                end else begin
                    if (cmd.pop_commit && alloc_cls_reg == CLASS_W'(c)) begin
                        head_reg[c] <= link_rd_reg;
                    end
                    if (cmd.push && push_cls == CLASS_W'(c)) begin
                        head_reg[c] <= LINK_W'(req_handle_reg);
                    end
                end
            end
        end
    end

    // Form the result
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            case (cmd.res_kind)
                RES_INIT: begin
                    res_handle_reg <= '0;
                    res_class_reg  <= '0;
                    res_status_reg <= ST_OK;
                end
                RES_BAD: begin
                    res_handle_reg <= '0;
                    res_class_reg  <= '0;
                    res_status_reg <= ST_BAD_CONFIG;
                end
                RES_NOBLK: begin
                    res_handle_reg <= '0;
                    res_class_reg  <= '0;
                    res_status_reg <= ST_NO_BLOCK;
                end
                RES_NOCLASS: begin
                    res_handle_reg <= '0;
                    res_class_reg  <= '0;
                    res_status_reg <= ST_NO_CLASS;
                end
                RES_KEEP: begin
                    res_handle_reg <= req_handle_reg;
                    res_class_reg  <= own_cls;
                    res_status_reg <= ST_OK;
                end
                RES_ALLOC: begin
                    res_handle_reg <= alloc_head_reg[HANDLE_W-1:0];
                    res_class_reg  <= alloc_cls_reg;
                    res_status_reg <= ST_OK;
                end
                default: begin
                    res_handle_reg <= '0;
                    res_class_reg  <= '0;
                    res_status_reg <= ST_OK;
                end
            endcase
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_handle_reg <= res_handle_reg;
            m_class_reg  <= res_class_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - HANDLE_W - CLASS_W){1'b0}}, m_class_reg, m_handle_reg};
    assign m_tuser  = m_status_reg;

    // Status to the controller
    assign stat.req_type   = req_type_reg;
    assign stat.owner_hit  = own_hit;
    assign stat.owner_fits = req_size_reg <= own_size;
    assign stat.alloc_hit  = alloc_hit;
    assign stat.total_over = cfg.total > SUM_W'(TOTAL_BLOCKS);
    assign stat.total_zero = cfg.total == '0;
    assign stat.walk_last  = walk_succ == cfg.total;
    assign stat.out_free   = !m_valid_reg || m_tready;

    // A pop reads only from a non-empty fitting list
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_read |-> alloc_hit)
        else $error("pop issued with no fitting free block");

    // The init walk stays inside the configured blocks
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> (SUM_W'(walk_ptr_reg) < cfg.total))
        else $error("init walk beyond configured blocks");

    // A direct push needs an owning class
    a_push_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && !cmd.pop_commit) |-> own_hit)
        else $error("push of a handle in no class");

endmodule

`default_nettype wire

### design/scbp_ctrl.sv
// Controller: sequences one request at a time through the datapath.
`default_nettype none

module scbp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  scbp_pkg::scbp_stat_t  stat,
    output scbp_pkg::scbp_cmd_t   cmd
);
    import scbp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_POP,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.res_set = 1'b1;
                state_next  = S_RESP;
                case (stat.req_type)
                    REQ_INIT: begin
                        if (stat.total_over) begin
                            cmd.heads_clear = 1'b1;
                            cmd.res_kind    = RES_BAD;
                        end else begin
                            cmd.heads_init = 1'b1;
                            cmd.res_kind   = RES_INIT;
                            if (!stat.total_zero) begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                    end
                    REQ_ALLOC: begin
                        if (stat.alloc_hit) begin
                            cmd.res_set  = 1'b0;
                            cmd.pop_read = 1'b1;
                            state_next   = S_POP;
                        end else begin
                            cmd.res_kind = RES_NOBLK;
                        end
                    end
                    REQ_FREE: begin
                        if (stat.owner_hit) begin
                            cmd.push     = 1'b1;
                            cmd.res_kind = RES_KEEP;
                        end else begin
                            cmd.res_kind = RES_NOCLASS;
                        end
                    end
                    REQ_REALLOC: begin
                        if (!stat.owner_hit) begin
                            cmd.res_kind = RES_NOCLASS;
                        end else if (stat.owner_fits) begin
                            cmd.res_kind = RES_KEEP;
                        end else if (stat.alloc_hit) begin
                            cmd.res_set  = 1'b0;
                            cmd.pop_read = 1'b1;
                            state_next   = S_POP;
                        end else begin
                            cmd.res_kind = RES_NOBLK;
                        end
                    end
                    default: begin
                        cmd.res_kind = RES_NOCLASS;
                    end
                endcase
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_RESP;
                end
            end
            S_POP: begin
                cmd.pop_commit = 1'b1;
                cmd.push       = (stat.req_type == REQ_REALLOC);
                cmd.res_set    = 1'b1;
                cmd.res_kind   = RES_ALLOC;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // A pop commit comes in the cycle right after its read
    a_pop_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_commit |-> $past(cmd.pop_read))
        else $error("pop commit without a preceding read");

    // The init walk runs without gaps until its last block
    a_walk_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.walk_step && !stat.walk_last) |=> cmd.walk_step)
        else $error("init walk interrupted");

    // A result never overwrites a beat still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a waiting beat");

endmodule

`default_nettype wire

### design/size_class_block_pool.sv
// Top level of the size class block pool allocator.
//
// Requests arrive as beats on the s_ channel: s_tuser carries the request
// type (init, allocate, free, reallocate), s_tdata the requested size and the
// handle. Each request yields exactly one beat on the m_ channel: s_tdata-like
// m_tdata carries the handle and class, m_tuser the status code.
// The user is to write class sizes and counts through the APB port only while
// no request is in flight; the block does not enforce it. Ranges are
// registered from the counts, lists follow at the next init. One request is
// worked at a time. Free, keep and error results, an init with counts beyond
// the store among them, pass decode and result load; an allocation that pops a
// block passes decode, a registered link memory read and result load; an init
// that builds the lists passes decode, a walk over the sum of class counts
// that writes one link memory entry per cycle, and result load. s_tready is
// high again in the cycle the result beat appears. While the receiver stalls,
// the result waits in the output register; a next request may be accepted and
// worked, and its result is held back until the output register is free.
// After reset all lists are empty, configuration is zero and no beat is valid;
// the link memory is not cleared, an init request builds the lists.
`default_nettype none

module size_class_block_pool #(
    parameter int MAX_CLASSES  = scbp_pkg::MAX_CLASSES_DEF,
    parameter int TOTAL_BLOCKS = scbp_pkg::TOTAL_BLOCKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] req_size, [25:16] handle_in, [31:26] zero
    input  logic [scbp_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [scbp_pkg::TYPE_W-1:0]      s_tuser,
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] handle_out, [11:10] class_out, [15:12] zero
    output logic [scbp_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [scbp_pkg::STATUS_W-1:0]    m_tuser,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scbp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [scbp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [scbp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import scbp_pkg::*;

    scbp_cfg_t  cfg;
    scbp_cmd_t  cmd;
    scbp_stat_t stat;

    scbp_regs #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scbp_dp #(
        .MAX_CLASSES  (MAX_CLASSES),
        .TOTAL_BLOCKS (TOTAL_BLOCKS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
